@@ rtl/core/ptwd_pkg.sv @@
package ptwd_pkg;

    localparam int DIST_W    = 17;
    localparam int ROOT_W    = 18;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int SQ_W      = 2 * DIST_W;
    localparam int SUM_W     = SQ_W + 1;
    localparam int M_TDATA_W = 24;
    localparam int NUM_SEG   = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [ROOT_W-1:0] root_t;
    typedef logic [ROOT_W+1:0] sq_rem_t;
    typedef logic [RAD_W-1:0]  rad_t;

endpackage

@@ rtl/core/point_to_wire_distance_unit.sv @@
// Distance from a query point to an orthogonally routed wire.
// Slave channel: one request per handshake carries the query point and the
// wire's start and end points (signed Q11.4). Master channel: one result per
// request, the floored minimum distance to the three wire segments (Q13.4,
// saturated at the field maximum).
// Each request passes a row of registered cells: setup stages, one
// remainder cell per projection fraction bit, squaring and summing, then one
// square-root cell per root bit, and a final minimum stage.
// Throughput: one request per cycle unless the output stalls; every
// stage holds a valid bit and moves on when the stage after it is empty
// or moving, so bubbles collapse.
// When the receiver stalls, the result holds in the output register and the
// row keeps accepting until it is full; s_tready then drops.
// Reset empties every stage; no result is pending afterwards.
module point_to_wire_distance_unit
    import ptwd_pkg::*;
#(
    parameter int COORD_WIDTH     = 16,
    parameter int T_FRACTION_BITS = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // point_x, point_y, start_x, start_y, end_x, end_y, zero fill
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // distance, zero fill
    output logic [M_TDATA_W-1:0]                     m_tdata
);

    localparam int CW      = COORD_WIDTH;
    localparam int DW      = COORD_WIDTH + 1;
    localparam int F       = T_FRACTION_BITS;
    localparam int TAG_W   = 2 * DW + 1;
    localparam int CMP_W   = (DW > DIST_W) ? DW : DIST_W;
    localparam int ST_CLS  = 4;
    localparam int ST_DIV0 = ST_CLS + 1;
    localparam int ST_SEL  = ST_DIV0 + F;
    localparam int ST_SQR  = ST_SEL + 1;
    localparam int ST_SUM  = ST_SQR + 1;
    localparam int ST_RT0  = ST_SUM + 1;
    localparam int ST_SEG  = ST_RT0 + ROOT_W;
    localparam int ST_OUT  = ST_SEG + 1;
    localparam int NST     = ST_OUT + 1;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] ready;

    always_comb begin
        ready[NST-1] = !valid_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ready[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NST; i++) begin
                if (ready[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_tready = ready[0];

    logic signed [CW-1:0] in_reg [6];
    logic signed [CW-1:0] pt_reg [6];
    logic signed [CW-1:0] mx_reg;

    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            for (int i = 0; i < 6; i++) begin
                in_reg[i] <= s_tdata[i*CW +: CW];
            end
        end
        if (ready[1]) begin
            pt_reg <= in_reg;
            mx_reg <= CW'(($signed({in_reg[2][CW-1], in_reg[2]})
                         + $signed({in_reg[4][CW-1], in_reg[4]})) >>> 1);
        end
    end

    function automatic logic signed [DW-1:0] sub_c(input logic signed [CW-1:0] x,
                                                  input logic signed [CW-1:0] y);
        return $signed({x[CW-1], x}) - $signed({y[CW-1], y});
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    logic signed [DW-1:0] a_reg [NUM_SEG];
    logic signed [DW-1:0] d_reg [NUM_SEG];
    logic signed [DW-1:0] b_reg [NUM_SEG];
    logic [DW-1:0] ua_reg [NUM_SEG];
    logic [DW-1:0] ud_reg [NUM_SEG];
    logic [DW-1:0] ub_reg [NUM_SEG];
    logic          behind_reg [NUM_SEG];
    logic [DW-1:0] rem_c [NUM_SEG][F+1];
    logic [DW-1:0] div_c [NUM_SEG][F+1];
    logic [TAG_W-1:0] tag_c [NUM_SEG][F+1];
    logic [DIST_W-1:0] r_reg [NUM_SEG];
    logic [DIST_W-1:0] bq_reg [NUM_SEG];
    logic              sat_reg [NUM_SEG];
    logic [SQ_W-1:0]   rr_reg [NUM_SEG];
    logic [SQ_W-1:0]   bb_reg [NUM_SEG];
    logic              sat2_reg [NUM_SEG];
    rad_t    rad_c  [NUM_SEG][ROOT_W+1];
    sq_rem_t srem_c [NUM_SEG][ROOT_W+1];
    root_t   root_c [NUM_SEG][ROOT_W+1];
    logic    sat_c  [NUM_SEG][ROOT_W+1];
    dist_t   seg_reg [NUM_SEG];
    dist_t   dist_reg;

    always_ff @(posedge aclk) begin
        if (ready[2]) begin
            a_reg[0] <= sub_c(pt_reg[0], pt_reg[2]);
            d_reg[0] <= sub_c(mx_reg, pt_reg[2]);
            b_reg[0] <= sub_c(pt_reg[1], pt_reg[3]);
            a_reg[1] <= sub_c(pt_reg[1], pt_reg[3]);
            d_reg[1] <= sub_c(pt_reg[5], pt_reg[3]);
            b_reg[1] <= sub_c(pt_reg[0], mx_reg);
            a_reg[2] <= sub_c(pt_reg[0], mx_reg);
            d_reg[2] <= sub_c(pt_reg[4], mx_reg);
            b_reg[2] <= sub_c(pt_reg[1], pt_reg[5]);
        end
        for (int s = 0; s < NUM_SEG; s++) begin
            if (ready[3]) begin
                ua_reg[s]     <= mag(a_reg[s]);
                ud_reg[s]     <= mag(d_reg[s]);
                ub_reg[s]     <= mag(b_reg[s]);
                behind_reg[s] <= (d_reg[s] == '0) || (a_reg[s] == '0)
                                 || (a_reg[s][DW-1] != d_reg[s][DW-1]);
            end
        end
    end

    for (genvar s = 0; s < NUM_SEG; s++) begin : g_seg
        logic [DW-1:0] rem_s0_reg;
        logic [DW-1:0] div_s0_reg;
        logic [TAG_W-1:0] tag_s0_reg;
        logic          in_seg;
        logic [DW-1:0] r_direct;
        logic [DW-1:0] ub_t;
        logic [DW-1:0] r_sel;

        always_ff @(posedge aclk) begin
            if (ready[ST_CLS]) begin
                rem_s0_reg <= ua_reg[s];
                div_s0_reg <= ud_reg[s];
                tag_s0_reg <= {!behind_reg[s] && (ua_reg[s] < ud_reg[s]),
                               behind_reg[s] ? ua_reg[s] : DW'(ua_reg[s] - ud_reg[s]),
                               ub_reg[s]};
            end
        end

        assign rem_c[s][0] = rem_s0_reg;
        assign div_c[s][0] = div_s0_reg;
        assign tag_c[s][0] = tag_s0_reg;

        for (genvar k = 0; k < F; k++) begin : g_div
            ptwd_div_cell #(.DW(DW), .TAG_W(TAG_W)) u_cell (
                .aclk  (aclk),
                .en    (ready[ST_DIV0+k]),
                .rem_i (rem_c[s][k]),
                .div_i (div_c[s][k]),
                .tag_i (tag_c[s][k]),
                .rem_o (rem_c[s][k+1]),
                .div_o (div_c[s][k+1]),
                .tag_o (tag_c[s][k+1])
            );
        end

        always_comb begin
            in_seg   = tag_c[s][F][TAG_W-1];
            r_direct = tag_c[s][F][2*DW-1:DW];
            ub_t     = tag_c[s][F][DW-1:0];
            r_sel    = in_seg ? (rem_c[s][F] >> F) : r_direct;
        end

        always_ff @(posedge aclk) begin
            if (ready[ST_SEL]) begin
                r_reg[s]   <= DIST_W'(r_sel);
                bq_reg[s]  <= DIST_W'(ub_t);
                sat_reg[s] <= (CMP_W'(r_sel) > CMP_W'(DIST_MAX))
                              || (CMP_W'(ub_t) > CMP_W'(DIST_MAX));
            end
            if (ready[ST_SQR]) begin
                rr_reg[s]   <= r_reg[s] * r_reg[s];
                bb_reg[s]   <= bq_reg[s] * bq_reg[s];
                sat2_reg[s] <= sat_reg[s];
            end
        end

        rad_t rad_s0_reg;
        logic sat_s0_reg;

        always_ff @(posedge aclk) begin
            if (ready[ST_SUM]) begin
                rad_s0_reg <= RAD_W'({1'b0, rr_reg[s]} + {1'b0, bb_reg[s]});
                sat_s0_reg <= sat2_reg[s];
            end
        end

        assign rad_c[s][0]  = rad_s0_reg;
        assign srem_c[s][0] = '0;
        assign root_c[s][0] = '0;
        assign sat_c[s][0]  = sat_s0_reg;

        for (genvar j = 0; j < ROOT_W; j++) begin : g_rt
            ptwd_sqrt_cell u_cell (
                .aclk   (aclk),
                .en     (ready[ST_RT0+j]),
                .rad_i  (rad_c[s][j]),
                .rem_i  (srem_c[s][j]),
                .root_i (root_c[s][j]),
                .sat_i  (sat_c[s][j]),
                .rad_o  (rad_c[s][j+1]),
                .rem_o  (srem_c[s][j+1]),
                .root_o (root_c[s][j+1]),
                .sat_o  (sat_c[s][j+1])
            );
        end

        always_ff @(posedge aclk) begin
            if (ready[ST_SEG]) begin
                if (sat_c[s][ROOT_W] || (root_c[s][ROOT_W] > ROOT_W'(DIST_MAX))) begin
                    seg_reg[s] <= DIST_MAX;
                end else begin
                    seg_reg[s] <= DIST_W'(root_c[s][ROOT_W]);
                end
            end
        end
    end

    dist_t min01;

    always_comb begin
        min01 = (seg_reg[1] < seg_reg[0]) ? seg_reg[1] : seg_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (ready[ST_OUT]) begin
            dist_reg <= (seg_reg[2] < min01) ? seg_reg[2] : min01;
        end
    end

    assign m_tvalid = valid_reg[ST_OUT];
    assign m_tdata  = M_TDATA_W'(dist_reg);

    a_empty_out_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("row refuses a request with an empty output register");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted request did not enter the first stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(dist_reg))
        else $error("stalled result lost or changed");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result pending right after reset");

endmodule

@@ rtl/core/ptwd_div_cell.sv @@
module ptwd_div_cell #(
    parameter int DW    = 17,
    parameter int TAG_W = 35
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DW-1:0]    rem_i,
    input  logic [DW-1:0]    div_i,
    input  logic [TAG_W-1:0] tag_i,
    output logic [DW-1:0]    rem_o,
    output logic [DW-1:0]    div_o,
    output logic [TAG_W-1:0] tag_o
);

    logic [DW:0]      dbl;
    logic             ge;
    logic [DW-1:0]    rem_next;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    div_reg;
    logic [TAG_W-1:0] tag_reg;

    always_comb begin
        dbl      = {rem_i, 1'b0};
        ge       = dbl >= {1'b0, div_i};
        rem_next = ge ? DW'(dbl - {1'b0, div_i}) : DW'(dbl);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            div_reg <= div_i;
            tag_reg <= tag_i;
        end
    end

    assign rem_o = rem_reg;
    assign div_o = div_reg;
    assign tag_o = tag_reg;

endmodule

@@ rtl/core/ptwd_sqrt_cell.sv @@
module ptwd_sqrt_cell
    import ptwd_pkg::*;
(
    input  logic    aclk,
    input  logic    en,
    input  rad_t    rad_i,
    input  sq_rem_t rem_i,
    input  root_t   root_i,
    input  logic    sat_i,
    output rad_t    rad_o,
    output sq_rem_t rem_o,
    output root_t   root_o,
    output logic    sat_o
);

    sq_rem_t rem_sh;
    sq_rem_t trial;
    sq_rem_t rem_next;
    root_t   root_next;
    rad_t    rad_reg;
    sq_rem_t rem_reg;
    root_t   root_reg;
    logic    sat_reg;

    always_comb begin
        rem_sh = {rem_i[ROOT_W-1:0], rad_i[RAD_W-1 -: 2]};
        trial  = {root_i, 2'b01};
        if (rem_sh >= trial) begin
            rem_next  = rem_sh - trial;
            root_next = {root_i[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh;
            root_next = {root_i[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= {rad_i[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            sat_reg  <= sat_i;
        end
    end

    assign rad_o  = rad_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign sat_o  = sat_reg;

endmodule
